@@ design/fcc_pkg.sv @@
// Package for the false-color colormap: shared types, fixed-point constants,
// the level-to-t lookup table and the polynomial coefficient tables.
// No dependencies; every other design file imports it.
package fcc_pkg;

   localparam int LEVEL_W     = 8;
   localparam int LEVEL_COUNT = 256;
   localparam int LEVEL_TOP   = LEVEL_COUNT - 1;
   localparam int LEVEL_DEPTH = 1 << LEVEL_W;
   localparam int SEL_W       = 3;
   localparam int COLOR_W     = 8;
   localparam int FRAC_W      = 16;
   localparam int ONE         = 1 << FRAC_W;
   localparam int TU_W        = FRAC_W + 1;  // unsigned t, 0 .. ONE
   localparam int T_W         = TU_W + 1;    // signed t
   localparam int CHAN_W      = 21;          // signed channel and accumulator
   localparam int PROD_W      = T_W + CHAN_W;
   localparam int NUM_CHAN    = 3;
   localparam int NUM_COEF    = 5;

   typedef enum logic [SEL_W-1:0] {
      MAP_JET     = 3'd0,
      MAP_HOT     = 3'd1,
      MAP_PLASMA  = 3'd2,
      MAP_INFERNO = 3'd3,
      MAP_VIRIDIS = 3'd4
   } map_type;

   typedef logic signed [T_W-1:0]    tq_type;
   typedef logic signed [CHAN_W-1:0] chan_type;

   typedef struct packed {
      logic [SEL_W-1:0]            sel;
      tq_type                      t;
      chan_type [NUM_CHAN-1:0]     acc;
      chan_type [NUM_CHAN-1:0]     dir;
   } fcc_stage_type;

   typedef struct packed {
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } fcc_rgb_type;

   typedef logic [LEVEL_DEPTH-1:0][TU_W-1:0] t_lut_type;

   // Level normalized to t = level / LEVEL_TOP in Q2.16, rounded half up.
   // Levels above the top saturate to t = 1.0.
   function automatic t_lut_type build_t_lut();
      t_lut_type lut;
      int        lvl;
      for (int i = 0; i < LEVEL_DEPTH; i++) begin
         lvl    = (i > LEVEL_TOP) ? LEVEL_TOP : i;
         lut[i] = TU_W'((lvl * 2 * ONE + LEVEL_TOP) / (2 * LEVEL_TOP));
      end
      return lut;
   endfunction

   localparam t_lut_type T_LUT = build_t_lut();

   // Coefficients c0..c4 in Q2.16; cubics carry a zero leading coefficient.
   localparam int PLASMA_COEF [NUM_CHAN][NUM_COEF] = '{
      '{  3302, 132937,  -85986,  15277,     0},
      '{  1953,  12595,   93653,-108209, 32768},
      '{ 34601, 103097, -162634,  57697,     0}
   };
   localparam int VIRIDIS_COEF [NUM_CHAN][NUM_COEF] = '{
      '{ 17498,    262,   32392,  15378,     0},
      '{   319,  66495,  -34836,  33557,     0},
      '{ 21589,  93302, -147633,  32734,     0}
   };

   function automatic chan_type poly_coef(logic [SEL_W-1:0] sel, logic [1:0] ch,
                                          logic [2:0] k);
      chan_type c;
      c = '0;
      if (sel == MAP_PLASMA) begin
         c = chan_type'(PLASMA_COEF[ch][k]);
      end else if (sel == MAP_VIRIDIS) begin
         c = chan_type'(VIRIDIS_COEF[ch][k]);
      end
      return c;
   endfunction

endpackage

@@ design/fcc_ifs.sv @@
// Channel interfaces of the false-color colormap: level requests, RGB
// responses and the map select register write. Depends on fcc_pkg.
interface fcc_req_if import fcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] level;
   modport source (output valid, level, input ready);
   modport sink (input valid, level, output ready);
endinterface

interface fcc_rsp_if import fcc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] red;
   logic [COLOR_W-1:0] green;
   logic [COLOR_W-1:0] blue;
   modport source (output valid, red, green, blue, input ready);
   modport sink (input valid, red, green, blue, output ready);
endinterface

interface fcc_csr_if import fcc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] map_select;
   modport source (output valid, map_select, input ready);
   modport sink (input valid, map_select, output ready);
endinterface

@@ design/fcc_norm.sv @@
// First pipeline stage: converts the level to t in Q2.16 through the
// constant lookup table and captures the map select. Depends on fcc_pkg.
module fcc_norm import fcc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [LEVEL_W-1:0] level,
   input  logic [SEL_W-1:0]   sel,
   output logic               out_valid,
   input  logic               out_ready,
   output fcc_stage_type      out_stage
);

   logic          valid_ff;
   fcc_stage_type stage_ff;
   fcc_stage_type stage_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      stage_in     = '0;
      stage_in.sel = sel;
      stage_in.t   = tq_type'({1'b0, T_LUT[level]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ design/fcc_ramp.sv @@
// Second pipeline stage: evaluates the piecewise linear maps (jet, hot,
// inferno) and loads the polynomial accumulators. Depends on fcc_pkg.
module fcc_ramp import fcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  fcc_stage_type in_stage,
   output logic          out_valid,
   input  logic          out_ready,
   output fcc_stage_type out_stage
);

   logic                valid_ff;
   fcc_stage_type       stage_ff;
   fcc_stage_type       stage_in;
   chan_type            tc;
   logic signed [35:0]  inf_prod;
   chan_type            inf_b;

   assign in_ready = !valid_ff || out_ready;
   assign tc       = chan_type'(in_stage.t);
   assign inf_prod = 36'(tc) * 36'sd78643;

   always_comb begin
      inf_b = chan_type'(39322 - (inf_prod >>> FRAC_W));
      if (inf_b < 0) begin
         inf_b = '0;
      end else if (inf_b > 39322) begin
         inf_b = chan_type'(39322);
      end
   end

   always_comb begin
      stage_in     = in_stage;
      stage_in.dir = '0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         stage_in.acc[c] = poly_coef(in_stage.sel, 2'(c), 3'(NUM_COEF - 1));
      end
      if (in_stage.sel == MAP_JET) begin
         priority if (tc < 8192) begin
            stage_in.dir[2] = chan_type'(32768 + 4 * tc);
         end else if (tc < 24576) begin
            stage_in.dir[1] = chan_type'(4 * (tc - 8192));
            stage_in.dir[2] = chan_type'(ONE);
         end else if (tc < 40960) begin
            stage_in.dir[0] = chan_type'(4 * (tc - 24576));
            stage_in.dir[1] = chan_type'(ONE);
            stage_in.dir[2] = chan_type'(ONE - 4 * (tc - 24576));
         end else if (tc < 57344) begin
            stage_in.dir[0] = chan_type'(ONE);
            stage_in.dir[1] = chan_type'(ONE - 4 * (tc - 40960));
         end else begin
            stage_in.dir[0] = chan_type'(ONE - 4 * (tc - 57344));
         end
      end else if (in_stage.sel == MAP_HOT) begin
         // Slopes of 2.5 and 5 are exact, so the products reduce to a multiply by 5 and a shift.
         stage_in.dir[0] = chan_type'((5 * tc) >>> 1);
         stage_in.dir[1] = chan_type'((5 * (tc - 26214)) >>> 1);
         stage_in.dir[2] = chan_type'(5 * (tc - 52429));
      end else if (in_stage.sel == MAP_INFERNO) begin
         stage_in.dir[0] = chan_type'((3 * tc) >>> 1);
         stage_in.dir[1] = chan_type'(2 * (tc - 16384));
         stage_in.dir[2] = inf_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ design/fcc_horner.sv @@
// One Horner step of the polynomial maps on all three channels:
// acc becomes c[K] + floor(t * acc / 2^16). Depends on fcc_pkg.
module fcc_horner import fcc_pkg::*; #(
   parameter int K = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  fcc_stage_type in_stage,
   output logic          out_valid,
   input  logic          out_ready,
   output fcc_stage_type out_stage
);

   logic                      valid_ff;
   fcc_stage_type             stage_ff;
   fcc_stage_type             stage_in;
   logic signed [PROD_W-1:0]  prod [NUM_CHAN];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      stage_in = in_stage;
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod[c]         = PROD_W'(in_stage.t) * PROD_W'(in_stage.acc[c]);
         stage_in.acc[c] = chan_type'(poly_coef(in_stage.sel, 2'(c), 3'(K))
                                      + chan_type'(prod[c] >>> FRAC_W));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

@@ design/fcc_emit.sv @@
// Last pipeline stage and output register: picks the channel values of the
// selected map, clamps them to [0,1] and scales to 8 bits. Depends on fcc_pkg.
module fcc_emit import fcc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  fcc_stage_type in_stage,
   output logic          out_valid,
   input  logic          out_ready,
   output fcc_rgb_type   out_rgb
);

   logic               valid_ff;
   fcc_rgb_type        rgb_ff;
   fcc_rgb_type        rgb_in;
   chan_type           val   [NUM_CHAN];
   logic [TU_W-1:0]    clamp [NUM_CHAN];
   logic [24:0]        scaled [NUM_CHAN];
   logic [COLOR_W-1:0] color [NUM_CHAN];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (in_stage.sel == MAP_PLASMA || in_stage.sel == MAP_VIRIDIS) begin
            val[c] = in_stage.acc[c];
         end else if (in_stage.sel == MAP_JET || in_stage.sel == MAP_HOT
                      || in_stage.sel == MAP_INFERNO) begin
            val[c] = in_stage.dir[c];
         end else begin
            val[c] = '0;
         end
         priority if (val[c] < 0) begin
            clamp[c] = '0;
         end else if (val[c] > ONE) begin
            clamp[c] = TU_W'(ONE);
         end else begin
            clamp[c] = TU_W'(val[c]);
         end
         scaled[c] = 25'(clamp[c]) * 25'd255 + 25'd32768;
         color[c]  = scaled[c][FRAC_W+COLOR_W-1:FRAC_W];
      end
      rgb_in.red   = color[0];
      rgb_in.green = color[1];
      rgb_in.blue  = color[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rgb_ff <= rgb_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rgb   = rgb_ff;

endmodule

@@ design/false_color_colormap.sv @@
// Top level of the false-color colormap: map select register and the
// seven-stage pipeline. Depends on fcc_pkg, fcc_ifs and the fcc_* stages.
//
//   Channel   Direction  Payload                   Role
//   req_if    in         level[7:0]                scalar level to color
//   rsp_if    out        red, green, blue [7:0]    RGB color of the level
//   csr_if    in         map_select[2:0]           color map register write
//
// One transaction per cycle is sustained when rsp_if is not stalled; the stage
// chain is the lookup, ramps, four Horner multiplies and the output register.
// Each stage holds its data under back pressure and takes a new transaction
// as soon as its own register frees up, so bubbles close. Reset clears all
// valid bits and sets map_select to jet.
module false_color_colormap import fcc_pkg::*; (
   input logic         clock,
   input logic         reset,
   fcc_req_if.sink     req_if,
   fcc_rsp_if.source   rsp_if,
   fcc_csr_if.sink     csr_if
);

   localparam int NUM_STAGE = NUM_COEF + 1;

   logic [SEL_W-1:0] map_select_ff;
   logic             stg_valid [NUM_STAGE];
   logic             stg_ready [NUM_STAGE];
   fcc_stage_type    stg_data  [NUM_STAGE];
   fcc_rgb_type      rgb;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_select_ff <= SEL_W'(MAP_JET);
      end else if (csr_if.valid) begin
         map_select_ff <= csr_if.map_select;
      end
   end

   fcc_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .level     (req_if.level),
      .sel       (map_select_ff),
      .out_valid (stg_valid[0]),
      .out_ready (stg_ready[0]),
      .out_stage (stg_data[0])
   );

   fcc_ramp u_ramp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[0]),
      .in_ready  (stg_ready[0]),
      .in_stage  (stg_data[0]),
      .out_valid (stg_valid[1]),
      .out_ready (stg_ready[1]),
      .out_stage (stg_data[1])
   );

   // Horner steps for coefficients c3 down to c0.
   for (genvar s = 1; s < NUM_STAGE - 1; s++) begin : g_horner
      fcc_horner #(
         .K (NUM_COEF - 1 - s)
      ) u_horner (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_ready  (stg_ready[s]),
         .in_stage  (stg_data[s]),
         .out_valid (stg_valid[s+1]),
         .out_ready (stg_ready[s+1]),
         .out_stage (stg_data[s+1])
      );
   end

   fcc_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NUM_STAGE-1]),
      .in_ready  (stg_ready[NUM_STAGE-1]),
      .in_stage  (stg_data[NUM_STAGE-1]),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_rgb   (rgb)
   );

   assign rsp_if.red   = rgb.red;
   assign rsp_if.green = rgb.green;
   assign rsp_if.blue  = rgb.blue;

endmodule

@@ test/false_color_colormap_tb.sv @@
`timescale 1ns / 100ps
// Testbench for false_color_colormap: directed rows and random levels under every map select, each
// checked against a typed-in color or a fixed-point predictor. Depends on fcc_pkg and fcc_ifs.
module false_color_colormap_tb;
   import fcc_pkg::*;

   localparam int     MAX_IDLE_CYCLES = 1000;
   localparam int     DRAIN_CYCLES    = 16;
   localparam int     RANDOM_PHASES   = 16;
   localparam int     PHASE_ITEMS     = 106;

   localparam logic [SEL_W-1:0] MAP_BLANK_A = 3'd5;
   localparam logic [SEL_W-1:0] MAP_BLANK_B = 3'd6;
   localparam logic [SEL_W-1:0] MAP_BLANK_C = 3'd7;

   // Q3.16 constants of the jet, hot and inferno maps.
   localparam longint Q_EIGHTH      = 8192;
   localparam longint Q_3_EIGHTHS   = 24576;
   localparam longint Q_5_EIGHTHS   = 40960;
   localparam longint Q_7_EIGHTHS   = 57344;
   localparam longint Q_HALF        = 32768;
   localparam longint Q_QUARTER     = 16384;
   localparam longint Q_2_5         = 163840;
   localparam longint Q_0_4         = 26214;
   localparam longint Q_0_8         = 52429;
   localparam longint Q_5_0         = 327680;
   localparam longint Q_1_5         = 98304;
   localparam longint Q_0_6         = 39322;
   localparam longint Q_1_2         = 78643;

   // Polynomial terms c0..c4 per channel (red, green, blue); cubics have c4 = 0.
   localparam longint PLASMA_TERMS [3][5] = '{
      '{  3302, 132937,  -85986,  15277,     0},
      '{  1953,  12595,   93653,-108209, 32768},
      '{ 34601, 103097, -162634,  57697,     0}
   };
   localparam longint VIRIDIS_TERMS [3][5] = '{
      '{ 17498,    262,   32392,  15378,     0},
      '{   319,  66495,  -34836,  33557,     0},
      '{ 21589,  93302, -147633,  32734,     0}
   };

   typedef struct packed {
      logic [SEL_W-1:0]   sel;
      logic [LEVEL_W-1:0] level;
      logic               fixed;   // expected color typed in below
      fcc_rgb_type        rgb;
   } probe_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam probe_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{MAP_JET,     8'd0,   1'b1, '{8'd0,   8'd0,   8'd128}},
      '{MAP_JET,     8'd31,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd32,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd95,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd96,  1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd159, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd160, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd223, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd224, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_JET,     8'd255, 1'b1, '{8'd128, 8'd0,   8'd0}},
      '{MAP_HOT,     8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{MAP_HOT,     8'd102, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_HOT,     8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{MAP_PLASMA,  8'd0,   1'b1, '{8'd13,  8'd8,   8'd135}},
      '{MAP_PLASMA,  8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_INFERNO, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd153}},
      '{MAP_INFERNO, 8'd128, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_INFERNO, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{MAP_VIRIDIS, 8'd0,   1'b1, '{8'd68,  8'd1,   8'd84}},
      '{MAP_VIRIDIS, 8'd255, 1'b0, '{8'd0,   8'd0,   8'd0}},
      '{MAP_BLANK_A, 8'd170, 1'b1, '{8'd0,   8'd0,   8'd0}},
      '{MAP_BLANK_B, 8'd85,  1'b1, '{8'd0,   8'd0,   8'd0}},
      '{MAP_BLANK_C, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd0}}
   };

   logic clock = 1'b0;
   logic reset;

   fcc_req_if req_if ();
   fcc_rsp_if rsp_if ();
   fcc_csr_if csr_if ();

   false_color_colormap u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   always #5 clock = ~clock;

   logic [SEL_W-1:0] map_sel;
   fcc_rgb_type      pending_colors[$];
   int               mismatch_count = 0;
   bit               req_idle = 1'b1;
   bit               rsp_idle = 1'b1;
   int               rsp_wait = 0;
   int               idle_cycles = 0;

   // Product of two Q2.16 values, truncated toward minus infinity.
   function automatic longint q_mul(longint a, longint b);
      return (a * b) >>> FRAC_W;
   endfunction

   function automatic longint q_clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint poly_eval(bit viridis, int ch, longint t);
      longint acc;
      acc = viridis ? VIRIDIS_TERMS[ch][4] : PLASMA_TERMS[ch][4];
      for (int k = 3; k >= 0; k--) begin
         acc = (viridis ? VIRIDIS_TERMS[ch][k] : PLASMA_TERMS[ch][k]) + q_mul(t, acc);
      end
      return acc;
   endfunction

   function automatic logic [COLOR_W-1:0] to_intensity(longint c);
      longint v;
      v = q_clamp(c, 0, ONE);
      return COLOR_W'((v * 255 + Q_HALF) >>> FRAC_W);
   endfunction

   function automatic fcc_rgb_type color_of_level(logic [SEL_W-1:0] sel,
                                                  logic [LEVEL_W-1:0] lvl);
      longint      lv, t, r, g, b;
      fcc_rgb_type rgb;
      lv = (lvl > LEVEL_TOP) ? LEVEL_TOP : lvl;
      t  = (lv * 2 * ONE + LEVEL_TOP) / (2 * LEVEL_TOP);
      r  = 0;
      g  = 0;
      b  = 0;
      unique case (sel)
         MAP_JET: begin
            if (t < Q_EIGHTH) begin
               b = Q_HALF + 4 * t;
            end else if (t < Q_3_EIGHTHS) begin
               g = 4 * (t - Q_EIGHTH);
               b = ONE;
            end else if (t < Q_5_EIGHTHS) begin
               r = 4 * (t - Q_3_EIGHTHS);
               g = ONE;
               b = ONE - 4 * (t - Q_3_EIGHTHS);
            end else if (t < Q_7_EIGHTHS) begin
               r = ONE;
               g = ONE - 4 * (t - Q_5_EIGHTHS);
            end else begin
               r = ONE - 4 * (t - Q_7_EIGHTHS);
            end
         end
         MAP_HOT: begin
            r = q_mul(t, Q_2_5);
            g = q_mul(t - Q_0_4, Q_2_5);
            b = q_mul(t - Q_0_8, Q_5_0);
         end
         MAP_PLASMA: begin
            r = poly_eval(1'b0, 0, t);
            g = poly_eval(1'b0, 1, t);
            b = poly_eval(1'b0, 2, t);
         end
         MAP_INFERNO: begin
            r = q_mul(t, Q_1_5);
            g = 2 * (t - Q_QUARTER);
            b = q_clamp(Q_0_6 - q_mul(t, Q_1_2), 0, Q_0_6);
         end
         MAP_VIRIDIS: begin
            r = poly_eval(1'b1, 0, t);
            g = poly_eval(1'b1, 1, t);
            b = poly_eval(1'b1, 2, t);
         end
         default: begin
         end
      endcase
      rgb.red   = to_intensity(r);
      rgb.green = to_intensity(g);
      rgb.blue  = to_intensity(b);
      return rgb;
   endfunction

   // Called at a rising edge; returns at the edge where the level transaction is taken.
   task automatic send_level(input logic [LEVEL_W-1:0] lvl, input fcc_rgb_type want);
      int gap;
      gap = req_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.level <= lvl;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_colors.push_back(want);
   endtask

   // Drains the pipeline, then writes the map select register.
   task automatic write_map(input logic [SEL_W-1:0] sel);
      req_if.valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      csr_if.valid      <= 1'b1;
      csr_if.map_select <= sel;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      map_sel = sel;
   endtask

   // Response back pressure: a fresh stall length is drawn after each transaction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_wait     <= 0;
      end else if (rsp_wait != 0) begin
         rsp_wait     <= rsp_wait - 1;
         rsp_if.ready <= (rsp_wait == 1);
      end else if (rsp_if.valid && rsp_if.ready) begin
         int stall;
         stall = rsp_idle ? $urandom_range(0, 9) : 0;
         rsp_wait     <= stall;
         rsp_if.ready <= (stall == 0);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      fcc_rgb_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_colors.size() == 0) begin
            $error("response with no level outstanding: red %0d green %0d blue %0d",
                   rsp_if.red, rsp_if.green, rsp_if.blue);
            mismatch_count++;
         end else begin
            want = pending_colors.pop_front();
            if (rsp_if.red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_if.red);
               mismatch_count++;
            end
            if (rsp_if.green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_if.green);
               mismatch_count++;
            end
            if (rsp_if.blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_if.blue);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= MAX_IDLE_CYCLES) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      fcc_rgb_type      want;
      logic [LEVEL_W-1:0] lvl;
      logic [SEL_W-1:0] sel;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.level      <= '0;
      csr_if.valid      <= 1'b0;
      csr_if.map_select <= MAP_JET;
      map_sel = MAP_JET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // The first rows run on the reset value of the map select.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].sel != map_sel) write_map(DIRECTED[i].sel);
         want = DIRECTED[i].fixed ? DIRECTED[i].rgb
                                  : color_of_level(map_sel, DIRECTED[i].level);
         send_level(DIRECTED[i].level, want);
      end

      // Every select code once in order, then random ones.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         sel = (p < 8) ? SEL_W'(p) : SEL_W'($urandom_range(0, 7));
         write_map(sel);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 32 == 0) begin
               req_idle = ($urandom_range(0, 3) != 0);
               rsp_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 7) == 0) begin
               lvl = $urandom_range(0, 1) ? LEVEL_W'(LEVEL_TOP) : '0;
            end else begin
               lvl = $urandom_range(0, 255);
            end
            send_level(lvl, color_of_level(map_sel, lvl));
         end
      end

      req_if.valid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ files.f @@
design/fcc_pkg.sv
design/fcc_ifs.sv
design/fcc_norm.sv
design/fcc_ramp.sv
design/fcc_horner.sv
design/fcc_emit.sv
design/false_color_colormap.sv
test/false_color_colormap_tb.sv
